@@ rtl/core/srn_pkg.sv @@
// srn_pkg: shared types and constants for the sample range normalizer.
// No dependencies; used by srn_div_stage and sample_range_normalizer_top.
`timescale 1ns / 1ps
`default_nettype none

package srn_pkg;

    localparam int unsigned SAMPLE_W        = 16;
    localparam int unsigned QUOT_W          = 16;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned NUM_DIV_STAGES  = QUOT_W / STEPS_PER_STAGE;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MAXIMUM = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SAMPLE_MAXIMUM = 1'b0,
        CFG_BYTE_SAMPLES   = 1'b1
    } t_cfg_index;

    // divider state: partial remainder, plus a shift word that holds the
    // unconsumed low numerator bits on top and the quotient bits below
    typedef struct packed {
        logic [SAMPLE_W-1:0] rem;
        logic [QUOT_W-1:0]   nq;
        logic                zero;  // force a zero result
        logic                bad;   // sample above maximum
    } t_div_word;

endpackage

`default_nettype wire

@@ rtl/core/srn_div_stage.sv @@
// srn_div_stage: one registered slice of the restoring divider, several
// quotient bits per slice. Depends on srn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srn_div_stage (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  srn_pkg::t_div_word        i_word,
    input  wire  [srn_pkg::SAMPLE_W-1:0]    i_divisor,
    output logic                            o_valid,
    input  wire                             i_ready,
    output srn_pkg::t_div_word              o_word
);

    logic               r_valid;
    srn_pkg::t_div_word r_word;
    srn_pkg::t_div_word n_word;

    always_comb begin
        logic [srn_pkg::SAMPLE_W:0] trial;
        logic                       q_bit;
        n_word = i_word;
        for (int k = 0; k < int'(srn_pkg::STEPS_PER_STAGE); k++) begin
            trial = {n_word.rem, n_word.nq[srn_pkg::QUOT_W-1]};
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
                q_bit = 1'b1;
            end else begin
                q_bit = 1'b0;
            end
            n_word.rem = trial[srn_pkg::SAMPLE_W-1:0];
            n_word.nq  = {n_word.nq[srn_pkg::QUOT_W-2:0], q_bit};
        end
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ rtl/core/sample_range_normalizer_top.sv @@
// Pipeline: one front stage that forms the numerator, then four divider
// stages of four quotient bits each, all registered.
// Throughput: one word per cycle; each stage holds its word while the next
// is full, so a stall at the output backs up stage by stage.
// Reset: synchronous active low; clears all stage valid bits and loads the
// configuration registers with maximum 65535 and 16-bit samples.
// Depends on srn_pkg and srn_div_stage.
`timescale 1ns / 1ps
`default_nettype none

module sample_range_normalizer_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_we,
    input  wire  [0:0]                      i_cfg_index,
    input  wire  [srn_pkg::SAMPLE_W-1:0]    i_cfg_data,
    // input words
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [srn_pkg::SAMPLE_W-1:0]    i_raw_sample,
    // result words
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [srn_pkg::QUOT_W-1:0]      o_scaled_sample,
    output logic                            o_out_of_range
);

    localparam int unsigned NS = srn_pkg::NUM_DIV_STAGES;
    localparam int unsigned SW = srn_pkg::SAMPLE_W;

    logic [SW-1:0] r_sample_maximum;
    logic          r_byte_samples;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_maximum <= srn_pkg::RST_SAMPLE_MAXIMUM;
            r_byte_samples   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (srn_pkg::t_cfg_index'(i_cfg_index))
                srn_pkg::CFG_SAMPLE_MAXIMUM: r_sample_maximum <= i_cfg_data;
                srn_pkg::CFG_BYTE_SAMPLES:   r_byte_samples   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front stage: numerator = value * 65535 + maximum / 2
    logic               r_front_valid;
    srn_pkg::t_div_word r_front_word;
    srn_pkg::t_div_word n_front_word;
    logic               front_ready;
    logic [SW-1:0]      value;
    logic [2*SW-1:0]    numer;

    logic               div_valid [NS+1];
    logic               div_ready [NS+1];
    srn_pkg::t_div_word div_word  [NS+1];

    always_comb begin
        value = r_byte_samples ? {8'h00, i_raw_sample[7:0]} : i_raw_sample;
        numer = {value, {SW{1'b0}}} - {{SW{1'b0}}, value}
              + {{(SW+1){1'b0}}, r_sample_maximum[SW-1:1]};
        n_front_word.rem  = numer[2*SW-1:SW];
        n_front_word.nq   = numer[SW-1:0];
        n_front_word.bad  = value > r_sample_maximum;
        n_front_word.zero = n_front_word.bad || (r_sample_maximum == '0);
    end

    assign front_ready = ~r_front_valid | div_ready[0];
    assign o_in_ready  = front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (front_ready) begin
            r_front_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_ready && i_in_valid) begin
            r_front_word <= n_front_word;
        end
    end

    assign div_valid[0] = r_front_valid;
    assign div_word[0]  = r_front_word;

    for (genvar g = 0; g < NS; g++) begin : g_div
        srn_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (div_valid[g]),
            .o_ready   (div_ready[g]),
            .i_word    (div_word[g]),
            .i_divisor (r_sample_maximum),
            .o_valid   (div_valid[g+1]),
            .i_ready   (div_ready[g+1]),
            .o_word    (div_word[g+1])
        );
    end

    assign div_ready[NS]   = i_out_ready;
    assign o_out_valid     = div_valid[NS];
    assign o_scaled_sample = div_word[NS].zero ? '0 : div_word[NS].nq;
    assign o_out_of_range  = div_word[NS].bad;

    // a flagged sample always reads as zero
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_scaled_sample == '0)
        else $error("out of range word with nonzero result");

    // zero maximum never lets the divider result through
    a_zero_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_sample_maximum == '0 |-> o_scaled_sample == '0)
        else $error("nonzero result with zero maximum");

    // an empty output stage means the whole pipe can move
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_front_valid)
        else $error("valid left set after reset");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench: self-checking bench for sample_range_normalizer_top.
// Uses srn_pkg for widths, full-scale constant and register indexes. Predicts
// each rescaled word in a scoreboard class and checks every result in order.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_WAIT  = 10;

    typedef struct {
        logic [srn_pkg::QUOT_W-1:0] scaled;
        logic                       oor;
    } t_expect;

    // rescale predictor plus the in-order list of results still owed
    class scaled_sample_board;
        logic [srn_pkg::SAMPLE_W-1:0] max_reg;
        logic                         byte_mode;
        t_expect                      pending[$];
        int                           n_errors;

        function new();
            max_reg   = srn_pkg::RST_SAMPLE_MAXIMUM;
            byte_mode = 1'b0;
            n_errors  = 0;
        endfunction

        function void set_register(srn_pkg::t_cfg_index idx,
                                   logic [srn_pkg::SAMPLE_W-1:0] data);
            case (idx)
                srn_pkg::CFG_SAMPLE_MAXIMUM: max_reg = data;
                srn_pkg::CFG_BYTE_SAMPLES:   byte_mode = data[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [srn_pkg::SAMPLE_W-1:0] raw);
            t_expect                      e;
            logic [srn_pkg::SAMPLE_W-1:0] value;
            logic [31:0]                  num;
            value    = byte_mode ? {8'h00, raw[7:0]} : raw;
            e.scaled = '0;
            e.oor    = 1'b0;
            if (value > max_reg) begin
                e.oor = 1'b1;
            end else if (max_reg != 0) begin
                // value <= max here, so the quotient fits 16 bits
                num      = 32'(value) * 32'(srn_pkg::FULL_SCALE) + 32'(max_reg >> 1);
                e.scaled = srn_pkg::QUOT_W'(num / 32'(max_reg));
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [srn_pkg::QUOT_W-1:0] scaled, logic oor);
            t_expect e;
            if (pending.size() == 0) begin
                $error("unexpected word: scaled_sample=%0d out_of_range=%0d",
                       scaled, oor);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            if (scaled !== e.scaled) begin
                $error("scaled_sample: expected %0d, got %0d", e.scaled, scaled);
                n_errors++;
            end
            if (oor !== e.oor) begin
                $error("out_of_range: expected %0d, got %0d", e.oor, oor);
                n_errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [0:0]                   i_cfg_index = srn_pkg::CFG_SAMPLE_MAXIMUM;
    logic [srn_pkg::SAMPLE_W-1:0] i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [srn_pkg::SAMPLE_W-1:0] i_raw_sample = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [srn_pkg::QUOT_W-1:0]   o_scaled_sample;
    logic                         o_out_of_range;

    scaled_sample_board board = new();

    int burst_left = 0;
    bit no_gaps = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_active = 1'b0;
    int idle_cycles = 0;

    sample_range_normalizer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_raw_sample    (i_raw_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scaled_sample (o_scaled_sample),
        .o_out_of_range  (o_out_of_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_scaled_sample, o_out_of_range);
    end

    // no progress on either channel for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[sample_range_normalizer_top] ERROR");
            $finish;
        end
    end

    // result side pacing: runs of one pattern, plus a long hold on request
    initial begin : result_pacing
        int mode;
        int run;
        forever begin
            if (hold_off_req) begin
                hold_active = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                hold_off_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                run  = $urandom_range(8, 40);
                repeat (run) begin
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= 1'($urandom_range(0, 1));
                        2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= ~i_out_ready;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // valid stays up across a burst; a gap drops it first
    task automatic send_sample(input logic [srn_pkg::SAMPLE_W-1:0] raw);
        int gap;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_raw_sample <= raw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_sample(raw);
    endtask

    // stop sending and wait for every owed word, then let the pipe go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (board.pending.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [srn_pkg::SAMPLE_W-1:0] mx,
                                input logic byte_mode);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= srn_pkg::CFG_SAMPLE_MAXIMUM;
        i_cfg_data  <= mx;
        board.set_register(srn_pkg::CFG_SAMPLE_MAXIMUM, mx);
        @(posedge i_clk);
        i_cfg_index <= srn_pkg::CFG_BYTE_SAMPLES;
        i_cfg_data  <= {{(srn_pkg::SAMPLE_W-1){1'b0}}, byte_mode};
        board.set_register(srn_pkg::CFG_BYTE_SAMPLES,
                           {{(srn_pkg::SAMPLE_W-1){1'b0}}, byte_mode});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly legal samples, some at or next to the maximum, the rest anything
    function automatic logic [srn_pkg::SAMPLE_W-1:0] pick_sample(
            logic [srn_pkg::SAMPLE_W-1:0] mx, logic byte_mode);
        logic [srn_pkg::SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: s = srn_pkg::SAMPLE_W'($urandom_range(0, mx));
            6, 7:             s = mx + srn_pkg::SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
            default:          s = srn_pkg::SAMPLE_W'($urandom());
        endcase
        // byte mode ignores the top byte, so fill it with noise
        if (byte_mode && s <= 16'd255)
            s[15:8] = 8'($urandom());
        return s;
    endfunction

    initial begin : stimulus
        logic [srn_pkg::SAMPLE_W-1:0] mx;
        logic                         bm;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: full scale, samples pass through unchanged
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        settle();
        write_config(16'd1000, 1'b0);
        send_sample(16'd999);
        send_sample(16'd1000);
        send_sample(16'd1001);
        send_sample(16'hFFFF);
        settle();
        // odd numerator over max 2 lands exactly on a half
        write_config(16'd2, 1'b0);
        send_sample(16'd1);
        send_sample(16'd3);
        settle();
        // byte mode: low byte compared against the full maximum
        write_config(16'd100, 1'b1);
        send_sample(16'h0165);
        send_sample(16'hFF64);
        settle();
        write_config(16'hFFFF, 1'b1);
        send_sample(16'h1234);
        send_sample(16'hFFFF);
        settle();
        // zero maximum: no divide, only zero is legal
        write_config(16'd0, 1'b0);
        send_sample(16'd0);
        send_sample(16'd5);
        settle();
        write_config(16'd0, 1'b1);
        send_sample(16'h0100);
        settle();
        write_config(16'd1, 1'b0);
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd2);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 5))
                0:       mx = 16'hFFFF;
                1:       mx = 16'd1;
                2:       mx = 16'd255;
                3:       mx = srn_pkg::SAMPLE_W'($urandom_range(1, 300));
                4:       mx = srn_pkg::SAMPLE_W'($urandom_range(1, 65535));
                default: mx = ($urandom_range(0, 3) == 0)
                              ? 16'd0
                              : srn_pkg::SAMPLE_W'($urandom_range(256, 65535));
            endcase
            bm = 1'($urandom_range(0, 1));
            write_config(mx, bm);

            if (phase == 3) begin
                // fill the pipe against a held-off output
                hold_off_req = 1'b1;
                i_in_valid <= 1'b0;
                burst_left = 0;
                do @(posedge i_clk); while (!hold_active);
                no_gaps = 1'b1;
                repeat (40) send_sample(pick_sample(mx, bm));
                no_gaps = 1'b0;
            end
            repeat (60) send_sample(pick_sample(mx, bm));
            settle();
        end

        if (board.n_errors == 0)
            $display("[sample_range_normalizer_top] OK");
        else
            $display("[sample_range_normalizer_top] ERROR");
        $finish;
    end

endmodule
